// ===== rtl/core/fcsg_pkg.sv =====
// ----------------------------------------------------------------------------
// fcsg_pkg
// Shared types and constants for the filled circle span generator.
// ----------------------------------------------------------------------------
package fcsg_pkg;

  // Default largest brush radius.
  localparam int MAX_RADIUS_DEF = 31;

  // Largest usable frame size, then capped by the 10-bit coordinate range.
  localparam int MAX_FRAME   = 1024;
  localparam int COORD_LIMIT = 1024;
  localparam int FRAME_LIMIT = (MAX_FRAME < COORD_LIMIT) ? MAX_FRAME : COORD_LIMIT;

  // Field widths.
  localparam int COORD_W = 10;
  localparam int SIZE_W  = 11;
  localparam int RAD_W   = 5;
  localparam int MAT_W   = 2;
  localparam int ROW_W   = 12;  // signed row: centre row plus signed offset

  // Stream data widths.
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

  // Register reset values.
  localparam logic [RAD_W-1:0]  RADIUS_RST = 5'd10;
  localparam logic [SIZE_W-1:0] FRAME_RST  = 11'd1024;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROW,
    ST_SQRT,
    ST_EMIT
  } fcsg_state_t;

endpackage

// ===== rtl/core/filled_circle_span_generator.sv =====
// ----------------------------------------------------------------------------
// filled_circle_span_generator
// Turns a brush centre into one clipped horizontal span per frame row that
// the filled circle touches, using a shared bit-serial integer square root.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  in_     | slave     | in_tvalid/tready   | tdata: center_x, center_y, mat
//  out_    | master    | out_tvalid/tready  | tdata: row, x_first, x_last, mat;
//          |           |                    | tlast: final span of the request
//  cfg_    | slave     | cfg_valid/ready    | cfg_index, cfg_data (always ready)
//
//  One request at a time: in_tready is high only while the sequencer idles.
//  Each in-frame row goes through a setup step, RW square root steps (one
//  result bit per cycle in the shared root unit, RW = 5 at the default
//  MAX_RADIUS) and an emit step; a row outside the frame takes only the
//  setup step.
//  A centre outside the frame returns to idle at once with no spans.
//  The emit step waits while the output register holds an untaken span.
//  rst_n is synchronous; it clears control state and restores the registers.
//
module filled_circle_span_generator
  import fcsg_pkg::*;
#(
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input requests
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [9:0] center_x, [19:10] center_y,
                                            // [21:20] paint_material, [23:22] 0
  // spans
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [9:0] span_row, [19:10] x_first,
                                            // [29:20] x_last, [31:30] material
  output logic                  out_tlast,  // last_span
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [SIZE_W-1:0]     cfg_data
);

  // Radius width, signed offset width, root operand width.
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int DYW   = RW + 1;
  localparam int VW    = 2 * RW;
  localparam logic [VW:0] BIT_START = (VW+1)'(1) << (2 * (RW - 1));

  // Configuration registers
  logic [RAD_W-1:0]  radius_r;
  logic [SIZE_W-1:0] fw_r, fh_r;

  // Request and sequencer state
  fcsg_state_t        state_r, state_nxt;
  logic [COORD_W-1:0] cx_r, cx_nxt;
  logic [COORD_W-1:0] cy_r, cy_nxt;
  logic [MAT_W-1:0]   mat_r, mat_nxt;
  logic signed [DYW-1:0] dy_r, dy_nxt;

  // Shared root unit
  logic [VW:0] sq_v_r, sq_v_nxt;
  logic [VW:0] sq_res_r, sq_res_nxt;
  logic [VW:0] sq_bit_r, sq_bit_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic [COORD_W-1:0]  o_row_r, o_row_nxt;
  logic [COORD_W-1:0]  o_first_r, o_first_nxt;
  logic [COORD_W-1:0]  o_last_r, o_last_nxt;
  logic [MAT_W-1:0]    o_mat_r, o_mat_nxt;
  logic                o_tlast_r, o_tlast_nxt;

  // Derived values
  logic [SIZE_W-1:0]     eff_w, eff_h;
  logic [RW-1:0]         r_eff;
  logic signed [ROW_W-1:0] row;
  logic                  row_in;
  logic                  dy_at_end;
  logic [RW-1:0]         ady;
  logic [VW-1:0]         rsq, dysq;
  logic [VW:0]           sq_trial;
  logic [RW-1:0]         h;
  logic [SIZE_W-1:0]     right_sum;
  logic                  out_free;
  logic [COORD_W-1:0]    in_cx, in_cy;
  logic [MAT_W-1:0]      in_mat;

  assign in_cx  = in_tdata[COORD_W-1:0];
  assign in_cy  = in_tdata[2*COORD_W-1:COORD_W];
  assign in_mat = in_tdata[2*COORD_W+MAT_W-1:2*COORD_W];

  // Saturate sizes and radius.
  assign eff_w = (fw_r > SIZE_W'(FRAME_LIMIT)) ? SIZE_W'(FRAME_LIMIT) : fw_r;
  assign eff_h = (fh_r > SIZE_W'(FRAME_LIMIT)) ? SIZE_W'(FRAME_LIMIT) : fh_r;
  assign r_eff = ({1'b0, radius_r} > (RAD_W+1)'(MAX_RADIUS)) ?
                 RW'(MAX_RADIUS) : RW'(radius_r);

  // Current row and whether it lies in the frame.
  assign row = $signed({{(ROW_W-COORD_W){1'b0}}, cy_r}) +
               {{(ROW_W-DYW){dy_r[DYW-1]}}, dy_r};
  assign row_in    = !row[ROW_W-1] && (row[SIZE_W-1:0] < eff_h);
  assign dy_at_end = (dy_r == $signed({1'b0, r_eff}));

  // Root operand r*r - dy*dy (never negative, |dy| <= r).
  assign ady  = dy_r[DYW-1] ? RW'(-dy_r) : RW'(dy_r);
  assign rsq  = VW'(r_eff) * VW'(r_eff);
  assign dysq = VW'(ady) * VW'(ady);

  assign sq_trial  = sq_res_r + sq_bit_r;
  assign h         = sq_res_r[RW-1:0];
  assign right_sum = {1'b0, cx_r} + SIZE_W'(h);
  assign out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      fw_r     <= FRAME_RST;
      fh_r     <= FRAME_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RADIUS:       radius_r <= cfg_data[RAD_W-1:0];
        CFG_FRAME_WIDTH:  fw_r     <= cfg_data;
        CFG_FRAME_HEIGHT: fh_r     <= cfg_data;
        default: ;  // unknown index: dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    mat_r     <= mat_nxt;
    dy_r      <= dy_nxt;
    sq_v_r    <= sq_v_nxt;
    sq_res_r  <= sq_res_nxt;
    sq_bit_r  <= sq_bit_nxt;
    o_row_r   <= o_row_nxt;
    o_first_r <= o_first_nxt;
    o_last_r  <= o_last_nxt;
    o_mat_r   <= o_mat_nxt;
    o_tlast_r <= o_tlast_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    mat_nxt       = mat_r;
    dy_nxt        = dy_r;
    sq_v_nxt      = sq_v_r;
    sq_res_nxt    = sq_res_r;
    sq_bit_nxt    = sq_bit_r;
    out_valid_nxt = out_valid_r && !out_tready;
    o_row_nxt     = o_row_r;
    o_first_nxt   = o_first_r;
    o_last_nxt    = o_last_r;
    o_mat_nxt     = o_mat_r;
    o_tlast_nxt   = o_tlast_r;
    in_tready     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cx_nxt  = in_cx;
          cy_nxt  = in_cy;
          mat_nxt = in_mat;
          dy_nxt  = -$signed({1'b0, r_eff});
          // centre outside the frame: nothing to draw
          if (({1'b0, in_cx} < eff_w) && ({1'b0, in_cy} < eff_h)) begin
            state_nxt = ST_ROW;
          end
        end
      end
      ST_ROW: begin
        if (row_in) begin
          sq_v_nxt   = {1'b0, rsq - dysq};
          sq_res_nxt = '0;
          sq_bit_nxt = BIT_START;
          state_nxt  = ST_SQRT;
        end else if (dy_at_end) begin
          state_nxt = ST_IDLE;
        end else begin
          dy_nxt = dy_r + DYW'(1);
        end
      end
      ST_SQRT: begin
        // one result bit per cycle
        if (sq_v_r >= sq_trial) begin
          sq_v_nxt   = sq_v_r - sq_trial;
          sq_res_nxt = (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_nxt = sq_res_r >> 1;
        end
        sq_bit_nxt = sq_bit_r >> 2;
        if ((sq_bit_r >> 2) == '0) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_row_nxt     = row[COORD_W-1:0];
          o_first_nxt   = (cx_r >= COORD_W'(h)) ? cx_r - COORD_W'(h) : '0;
          o_last_nxt    = (right_sum > eff_w - SIZE_W'(1)) ?
                          COORD_W'(eff_w - SIZE_W'(1)) : right_sum[COORD_W-1:0];
          o_mat_nxt     = mat_r;
          // last in-frame row: bottom of the circle or bottom of the frame
          o_tlast_nxt   = dy_at_end || (row[SIZE_W-1:0] == eff_h - SIZE_W'(1));
          if (o_tlast_nxt) begin
            state_nxt = ST_IDLE;
          end else begin
            dy_nxt    = dy_r + DYW'(1);
            state_nxt = ST_ROW;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {o_mat_r, o_last_r, o_first_r, o_row_r};
  assign out_tlast  = o_tlast_r;

endmodule

// ===== rtl/core/fcsg_checker.sv =====
// ----------------------------------------------------------------------------
// fcsg_checker
// Port-level checks for the filled circle span generator.
// ----------------------------------------------------------------------------
module fcsg_checker
  import fcsg_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  // stalled span holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("span changed while stalled");

  // a non-final span means the request is still in progress
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("ready while a request still has spans to go");

  // span never inverted: clipping keeps the centre column inside
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[19:10] <= out_tdata[29:20])
    else $error("x_first beyond x_last");

  // nothing pending right after reset
  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("span valid after reset");

endmodule

bind filled_circle_span_generator fcsg_checker u_fcsg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ===== tb/filled_circle_span_generator_test.sv =====
// ----------------------------------------------------------------------------
// filled_circle_span_generator_test
// Self-checking bench for the filled circle span generator. Brush strokes go
// in on the request stream, and every span that comes out is checked against
// spans worked out locally from the stroke and the current register settings.
// ----------------------------------------------------------------------------
module filled_circle_span_generator_test
  import fcsg_pkg::*;
();

  // Idle time after the last span before the registers are touched again.
  // The sequencer is already idle once the final span leaves; this is margin.
  localparam int SETTLE_CYCLES = 480;
  // Cycles with no handshake on any channel before the run is declared hung.
  localparam int QUIET_LIMIT   = 4000;
  // Register index past the end of the list; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int RANDOM_PHASES  = 6;
  localparam int STROKES_EACH   = 50;

  // One expected span, fields as they leave on the master side.
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] x_first;
    logic [COORD_W-1:0] x_last;
    logic [MAT_W-1:0]   material;
    logic               last_flag;
  } span_t;

  // Receiver behavior for a stretch of cycles.
  typedef enum logic [1:0] {
    RX_OPEN,    // always ready
    RX_COIN,    // ready half the time
    RX_SPARSE,  // ready one cycle in four
    RX_CHOKE    // long stalls, one ready cycle in sixteen
  } rx_mode_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the registers, span prediction, in-order check.
  // --------------------------------------------------------------------------
  class span_scoreboard;
    logic [RAD_W-1:0]  radius_reg;
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    span_t       pending_spans[$];
    int          errors;
    int unsigned strokes_seen;
    int unsigned spans_seen;

    function new();
      radius_reg   = RADIUS_RST;
      width_reg    = FRAME_RST;
      height_reg   = FRAME_RST;
      errors       = 0;
      strokes_seen = 0;
      spans_seen   = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
      case (idx)
        CFG_RADIUS:       radius_reg = val[RAD_W-1:0];
        CFG_FRAME_WIDTH:  width_reg  = val;
        CFG_FRAME_HEIGHT: height_reg = val;
        default: ;  // unmapped index: no effect
      endcase
    endfunction

    // Frame size as the block uses it: capped at the coordinate range.
    function int clip_size(logic [SIZE_W-1:0] size);
      return (int'(size) > FRAME_LIMIT) ? FRAME_LIMIT : int'(size);
    endfunction

    function int frame_cols();
      return clip_size(width_reg);
    endfunction

    function int frame_rows();
      return clip_size(height_reg);
    endfunction

    function int root_floor(int v);
      int h;
      h = 0;
      while ((h + 1) * (h + 1) <= v) h++;
      return h;
    endfunction

    function int pending();
      return pending_spans.size();
    endfunction

    // Accepted stroke: queue one span per in-frame row, last one flagged.
    function void plan_spans(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                             logic [MAT_W-1:0] mat);
      int    w, hgt, r, dy, row, h, lo, hi;
      bit    have;
      span_t s;
      strokes_seen++;
      w    = frame_cols();
      hgt  = frame_rows();
      r    = (int'(radius_reg) > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : int'(radius_reg);
      have = 1'b0;
      s    = '0;
      if (int'(cx) >= w || int'(cy) >= hgt) return;
      for (dy = -r; dy <= r; dy++) begin
        row = int'(cy) + dy;
        if (row >= 0 && row < hgt) begin
          if (have) pending_spans.push_back(s);
          h  = root_floor(r * r - dy * dy);
          lo = int'(cx) - h;
          hi = int'(cx) + h;
          if (lo < 0) lo = 0;
          if (hi > w - 1) hi = w - 1;
          s.row       = row[COORD_W-1:0];
          s.x_first   = lo[COORD_W-1:0];
          s.x_last    = hi[COORD_W-1:0];
          s.material  = mat;
          s.last_flag = 1'b0;
          have        = 1'b1;
        end
      end
      if (have) begin
        s.last_flag = 1'b1;
        pending_spans.push_back(s);
      end
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_span(logic [OUT_DATA_W-1:0] data, logic last);
      span_t want;
      if (pending_spans.size() == 0) begin
        report($sformatf("unexpected span, tdata=%h tlast=%b", data, last));
        return;
      end
      want = pending_spans.pop_front();
      spans_seen++;
      if (data[9:0] !== want.row)
        report($sformatf("span_row got %0d want %0d", data[9:0], want.row));
      if (data[19:10] !== want.x_first)
        report($sformatf("x_first got %0d want %0d (row %0d)",
                         data[19:10], want.x_first, want.row));
      if (data[29:20] !== want.x_last)
        report($sformatf("x_last got %0d want %0d (row %0d)",
                         data[29:20], want.x_last, want.row));
      if (data[31:30] !== want.material)
        report($sformatf("material got %0d want %0d (row %0d)",
                         data[31:30], want.material, want.row));
      if (last !== want.last_flag)
        report($sformatf("tlast got %b want %b (row %0d)", last, want.last_flag, want.row));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT and bus signals
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [9:0] center_x, [19:10] center_y,
                                     // [21:20] paint_material, [23:22] 0
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [9:0] span_row, [19:10] x_first,
                                     // [29:20] x_last, [31:30] material
  logic                  out_tlast;  // last_span
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [SIZE_W-1:0]     cfg_data;

  span_scoreboard board;
  int             settings_used = 0;
  int             quiet_cycles  = 0;
  rx_mode_t       rx_mode       = RX_OPEN;
  int unsigned    rx_left       = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  filled_circle_span_generator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Receiver: ready pattern changes mode at random, so stalls land on setup,
  // root and emit steps alike, with open stretches between.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(8, 64);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
      default:   out_tready <= (rx_left[3:0] == 4'd0);
    endcase
  end

  // Span monitor: values read at the edge are the pre-edge ones the DUT used.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_span(out_tdata, out_tlast);
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles, %0d spans outstanding",
               quiet_cycles, board.pending());
      $display("FAIL filled_circle_span_generator");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers. Every task is entered right after a rising edge and returns
  // right after the edge at which its handshake completed. Valid is left high
  // so back-to-back requests never drop and re-raise it in one step.
  // --------------------------------------------------------------------------
  task automatic push_stroke(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                             input logic [MAT_W-1:0] mat);
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, mat, cy, cx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.plan_spans(cx, cy, mat);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_reg(idx, val);
  endtask

  // Radius word carries junk above bit 4 at times; only the low bits count.
  task automatic apply_setting(input logic [SIZE_W-1:0] rad_word,
                               input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                               input bit poke_spare);
    put_reg(CFG_RADIUS, rad_word);
    put_reg(CFG_FRAME_WIDTH, w);
    put_reg(CFG_FRAME_HEIGHT, h);
    if (poke_spare) put_reg(CFG_SPARE, SIZE_W'($urandom_range(0, 2047)));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Quiesce: all spans back, then a margin before the registers change.
  task automatic close_phase();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 5))
      0:       return SIZE_W'($urandom_range(1, 64));
      1:       return SIZE_W'($urandom_range(1024, 2047));  // saturates
      default: return SIZE_W'($urandom_range(1, 1024));
    endcase
  endfunction

  // Random strokes in bursts; most centres land inside the frame so the
  // row walk and clipping get exercised, the rest anywhere in range.
  task automatic random_phase(input int count);
    int ew, eh, burst_left, gap, n;
    logic [COORD_W-1:0] cx, cy;
    ew         = board.frame_cols();
    eh         = board.frame_rows();
    burst_left = $urandom_range(1, 10);
    for (n = 0; n < count; n++) begin
      if (ew > 0 && $urandom_range(0, 3) != 0) cx = COORD_W'($urandom_range(0, ew - 1));
      else                                     cx = COORD_W'($urandom_range(0, 1023));
      if (eh > 0 && $urandom_range(0, 3) != 0) cy = COORD_W'($urandom_range(0, eh - 1));
      else                                     cy = COORD_W'($urandom_range(0, 1023));
      push_stroke(cx, cy, MAT_W'($urandom_range(0, 3)));
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 10);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        if (gap > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int p;
    board      = new();
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_RADIUS;
    cfg_data   <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: radius 10, full frame. Corners, middle, bit patterns.
    push_stroke(10'd0,    10'd0,    2'd0);
    push_stroke(10'd1023, 10'd1023, 2'd3);
    push_stroke(10'd512,  10'd512,  2'd1);
    push_stroke(10'd0,    10'd1023, 2'd2);
    push_stroke(10'd1023, 10'd0,    2'd1);
    push_stroke(10'h2AA,  10'h155,  2'd2);
    push_stroke(10'h155,  10'h2AA,  2'd1);
    close_phase();

    // Zero radius (upper junk bits set) in a one-pixel frame; centres off
    // the frame on either axis give nothing. Unmapped index poked too.
    apply_setting(11'h7E0, 11'd1, 11'd1, 1'b1);
    push_stroke(10'd0, 10'd0, 2'd3);
    push_stroke(10'd1, 10'd0, 2'd1);
    push_stroke(10'd0, 10'd1, 2'd2);
    close_phase();

    // Largest radius; frame sizes beyond the coordinate range saturate.
    apply_setting(11'd31, 11'd2047, 11'd2047, 1'b0);
    push_stroke(10'd0,    10'd0,    2'd1);
    push_stroke(10'd1023, 10'd1023, 2'd2);
    push_stroke(10'd31,   10'd31,   2'd3);
    push_stroke(10'd1000, 10'd15,   2'd1);
    close_phase();

    // Zero width, then zero height: no spans at all.
    apply_setting(11'd1, 11'd0, 11'd100, 1'b0);
    push_stroke(10'd0, 10'd0, 2'd1);
    push_stroke(10'd5, 10'd5, 2'd2);
    close_phase();
    apply_setting(11'd5, 11'd100, 11'd0, 1'b0);
    push_stroke(10'd0,  10'd0,  2'd3);
    push_stroke(10'd50, 10'd50, 2'd1);
    close_phase();

    // Random settings, each followed by a stream of random strokes.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      apply_setting({SIZE_W'($urandom_range(0, 63)) << RAD_W} |
                      (($urandom_range(0, 3) == 0) ? SIZE_W'(31)
                                                   : SIZE_W'($urandom_range(0, 31))),
                    pick_size(), pick_size(), 1'($urandom_range(0, 1)));
      random_phase(STROKES_EACH);
      close_phase();
    end

    if (board.pending() != 0)
      board.report($sformatf("%0d spans never arrived", board.pending()));

    $display("covered %0d strokes and %0d spans over %0d register settings",
             board.strokes_seen, board.spans_seen, settings_used);
    if (board.errors == 0) begin
      $display("PASS filled_circle_span_generator");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("FAIL filled_circle_span_generator");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/fcsg_pkg.sv
rtl/core/filled_circle_span_generator.sv
rtl/core/fcsg_checker.sv
tb/filled_circle_span_generator_test.sv
